### design/dq_pkg.sv
// Shared types and codes for the double-ended queue core.
package dq_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 10;
  localparam int OCC_W  = 7;

  // Command codes
  localparam logic [2:0] CMD_PUSH_REAR  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_REAR   = 3'd3;
  localparam logic [2:0] CMD_FIND       = 3'd4;
  localparam logic [2:0] CMD_REMOVE     = 3'd5;
  localparam logic [2:0] CMD_DUMP       = 3'd6;
  localparam logic [2:0] CMD_DUMP_REV   = 3'd7;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Ring move codes
  localparam logic [1:0] RING_HOLD  = 2'd0;
  localparam logic [1:0] RING_LEFT  = 2'd1;
  localparam logic [1:0] RING_RIGHT = 2'd2;
  localparam logic [1:0] RING_WRITE = 2'd3;

  localparam logic signed [WORD_W-1:0] NEG_ONE = {WORD_W{1'b1}};

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         remove_count;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic                     inject;
    logic signed [WORD_W-1:0] value;
  } ring_ctl_t;

endpackage

### design/dq_cell.sv
// One storage cell of the rotating word ring.
module dq_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  dq_pkg::ring_ctl_t                ring_ctl,
  input  logic [IW-1:0]                    wr_index,
  input  logic signed [dq_pkg::WORD_W-1:0] from_prev,
  input  logic signed [dq_pkg::WORD_W-1:0] from_next,
  output logic signed [dq_pkg::WORD_W-1:0] word
);
  import dq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ring_ctl.mode)
      RING_LEFT: begin
        word <= from_next;
      end
      RING_RIGHT: begin
        // cell zero takes the pushed word instead of the wrapped one
        if (ring_ctl.inject && (IDX == 0)) begin
          word <= ring_ctl.value;
        end else begin
          word <= from_prev;
        end
      end
      RING_WRITE: begin
        if (wr_index == IW'(IDX)) begin
          word <= ring_ctl.value;
        end
      end
      default: begin
        word <= word;
      end
    endcase
  end

endmodule

### design/dq_ctrl.sv
// Command sequencer: steers the cell ring and builds result beats.
module dq_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  dq_pkg::req_t                     req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output dq_pkg::rsp_t                     rsp,
  input  logic signed [dq_pkg::WORD_W-1:0] front_word,
  output dq_pkg::ring_ctl_t                ring_ctl,
  output logic [$clog2(DEPTH)-1:0]         wr_index
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  localparam logic [2:0] SEQ_IDLE  = 3'd0;
  localparam logic [2:0] SEQ_SEEK  = 3'd1;
  localparam logic [2:0] SEQ_EXEC  = 3'd2;
  localparam logic [2:0] SEQ_RET   = 3'd3;
  localparam logic [2:0] SEQ_DUMP  = 3'd4;
  localparam logic [2:0] SEQ_RDUMP = 3'd5;

  logic [2:0]               state, state_next;
  logic [2:0]               cmd_q;
  logic signed [WORD_W-1:0] value_q;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            cnt, cnt_next;
  logic [CW-1:0]            ret, ret_next;
  logic                     miss, miss_next;
  logic                     req_accept, rsp_free, emit;
  logic                     empty, full, pos_ok;
  logic [CW-1:0]            seek, rm, pos_m1;
  logic signed [WORD_W-1:0] emit_data;
  logic [1:0]               emit_status;
  logic                     emit_last;
  rsp_t                     rsp_next;

  assign req_stall  = (state != SEQ_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign empty      = (count == '0);
  assign full       = (count == CW'(DEPTH));
  assign pos_ok     = (req.position != '0) && (req.position <= POS_W'(count));
  assign pos_m1     = CW'(req.position - POS_W'(1));
  assign rm         = (req.remove_count > POS_W'(count)) ? count : CW'(req.remove_count);
  assign wr_index   = count[IW-1:0];

  always_comb begin
    state_next      = state;
    count_next      = count;
    cnt_next        = cnt;
    ret_next        = ret;
    miss_next       = miss;
    seek            = '0;
    ring_ctl.mode   = RING_HOLD;
    ring_ctl.inject = 1'b0;
    ring_ctl.value  = value_q;
    emit            = 1'b0;
    emit_data       = '0;
    emit_status     = STATUS_OK;
    emit_last       = 1'b0;

    unique case (state)
      SEQ_IDLE: begin
        if (req_accept) begin
          miss_next = 1'b0;
          ret_next  = '0;
          unique case (req.cmd)
            CMD_POP_FRONT: begin
              miss_next = empty;
            end
            CMD_POP_REAR: begin
              miss_next = empty;
              if (!empty) begin
                seek     = count - CW'(1);
                ret_next = count - CW'(1);
              end
            end
            CMD_FIND: begin
              miss_next = !pos_ok;
              if (pos_ok) begin
                seek     = pos_m1;
                ret_next = pos_m1;
              end
            end
            CMD_REMOVE: begin
              seek = rm;
            end
            CMD_DUMP: begin
              miss_next = empty;
            end
            CMD_DUMP_REV: begin
              miss_next = empty;
              if (!empty) begin
                seek = count - CW'(1);
              end
            end
            default: begin
            end
          endcase
          // route: rotate first, stream a dump, or go straight to execute
          if (seek != '0) begin
            state_next = SEQ_SEEK;
            cnt_next   = seek;
          end else if (!empty && (req.cmd == CMD_DUMP)) begin
            state_next = SEQ_DUMP;
            cnt_next   = count;
          end else if (!empty && (req.cmd == CMD_DUMP_REV)) begin
            state_next = SEQ_RDUMP;
            cnt_next   = count;
          end else begin
            state_next = SEQ_EXEC;
          end
        end
      end

      SEQ_SEEK: begin
        // advance the ring toward the target word
        ring_ctl.mode = RING_LEFT;
        cnt_next      = cnt - CW'(1);
        if (cmd_q == CMD_REMOVE) begin
          count_next = count - CW'(1);
        end
        if (cnt == CW'(1)) begin
          if (cmd_q == CMD_DUMP_REV) begin
            state_next = SEQ_RDUMP;
            cnt_next   = count;
          end else begin
            state_next = SEQ_EXEC;
          end
        end
      end

      SEQ_EXEC: begin
        if (rsp_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = SEQ_IDLE;
          unique case (cmd_q)
            CMD_PUSH_REAR: begin
              if (full) begin
                emit_status = STATUS_FULL;
              end else begin
                ring_ctl.mode = RING_WRITE;
                count_next    = count + CW'(1);
              end
            end
            CMD_PUSH_FRONT: begin
              if (full) begin
                emit_status = STATUS_FULL;
              end else begin
                ring_ctl.mode   = RING_RIGHT;
                ring_ctl.inject = 1'b1;
                count_next      = count + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (miss) begin
                emit_data   = NEG_ONE;
                emit_status = STATUS_EMPTY;
              end else begin
                emit_data     = front_word;
                ring_ctl.mode = RING_LEFT;
                count_next    = count - CW'(1);
              end
            end
            CMD_POP_REAR: begin
              if (miss) begin
                emit_data   = NEG_ONE;
                emit_status = STATUS_EMPTY;
              end else begin
                emit_data  = front_word;
                count_next = count - CW'(1);
                if (ret != '0) begin
                  state_next = SEQ_RET;
                  cnt_next   = ret;
                end
              end
            end
            CMD_FIND: begin
              if (miss) begin
                emit_data   = NEG_ONE;
                emit_status = STATUS_EMPTY;
              end else begin
                emit_data = front_word;
                if (ret != '0) begin
                  state_next = SEQ_RET;
                  cnt_next   = ret;
                end
              end
            end
            CMD_REMOVE: begin
            end
            default: begin
              // dump of an empty deque
              emit_data   = NEG_ONE;
              emit_status = STATUS_EMPTY;
            end
          endcase
        end
      end

      SEQ_RET: begin
        // rotate back until the front word sits in cell zero again
        ring_ctl.mode = RING_RIGHT;
        cnt_next      = cnt - CW'(1);
        if (cnt == CW'(1)) begin
          state_next = SEQ_IDLE;
        end
      end

      SEQ_DUMP: begin
        if (rsp_free) begin
          emit          = 1'b1;
          emit_data     = front_word;
          emit_last     = (cnt == CW'(1));
          ring_ctl.mode = RING_LEFT;
          cnt_next      = cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state_next = SEQ_RET;
            cnt_next   = count;
          end
        end
      end

      SEQ_RDUMP: begin
        if (rsp_free) begin
          emit      = 1'b1;
          emit_data = front_word;
          emit_last = (cnt == CW'(1));
          cnt_next  = cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state_next = SEQ_IDLE;
          end else begin
            ring_ctl.mode = RING_RIGHT;
          end
        end
      end

      default: begin
        state_next = SEQ_IDLE;
      end
    endcase

    rsp_next.data      = emit_data;
    rsp_next.status    = emit_status;
    rsp_next.occupancy = OCC_W'(count_next);
    rsp_next.last      = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SEQ_IDLE;
      count     <= '0;
      cnt       <= '0;
      ret       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      cnt   <= cnt_next;
      ret   <= ret_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    miss <= miss_next;
    if (req_accept) begin
      cmd_q   <= req.cmd;
      value_q <= req.value;
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above depth");

  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    emit |-> (state == SEQ_EXEC || state == SEQ_DUMP || state == SEQ_RDUMP))
    else $error("result beat built outside a result state");

  a_rotate_count: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_SEEK || state == SEQ_RET) |-> (cnt != '0))
    else $error("rotation phase entered with zero steps");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> (state != SEQ_IDLE))
    else $error("accepted command left sequencer idle");

  a_rdump_end: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_RDUMP && emit && emit_last) |=> (state == SEQ_IDLE))
    else $error("reverse dump did not finish on its last beat");

endmodule

### design/double_ended_queue_core.sv
// Double-ended queue of signed words kept in a rotating ring of cells.
// Push, pop front and the empty cases register their result beat from the
// execute state. Pop rear and find rotate the ring left to the target word,
// emit it and rotate back; remove k rotates min(k, n) words off the front
// before its beat; a dump streams one beat per element while rotating and
// ends with the front word back in cell zero.
// Reset (rst, synchronous) empties the deque; stored words are not cleared.
module double_ended_queue_core #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  dq_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output dq_pkg::rsp_t rsp
);
  import dq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  // The ring keeps the front word in cell zero whenever the sequencer is idle,
  // with the rest following in order in the next cells. Every access reads
  // cell zero only: the ring rotates left to bring a deeper word to the front
  // and rotates right to put things back. A push at the front is a right
  // rotation that drops the pushed word into cell zero; a push at the rear
  // writes the cell just past the last element.
  logic signed [WORD_W-1:0] ring [DEPTH];
  ring_ctl_t                ring_ctl;
  logic [IW-1:0]            wr_index;

  // Sequencer: one command at a time, result beats go through an output
  // register so a waiting beat never blocks the next command's accept.
  dq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .front_word (ring[0]),
    .ring_ctl   (ring_ctl),
    .wr_index   (wr_index)
  );

  // Each cell talks only to its two neighbors; the ends wrap around.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_cell #(
      .IW (IW),
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .ring_ctl (ring_ctl),
      .wr_index (wr_index),
      .from_prev(ring[(i + DEPTH - 1) % DEPTH]),
      .from_next(ring[(i + 1) % DEPTH]),
      .word     (ring[i])
    );
  end

endmodule

### test/tb_top.sv
// Self-checking testbench for the double-ended queue core.
module tb_top;
  import dq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int HALF_PERIOD  = 6;
  // Worst case: every command a full dump under heavy response stalls, several times over
  localparam int CYCLE_LIMIT  = 600000;
  // Longest single command (dump of a full deque) plus margin
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int MAX_REPORTS  = 10;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Idle percentages for the request and response sides
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int cycle_count   = 0;

  // Shadow copy of the ring: contents, front pointer and element count
  logic signed [WORD_W-1:0] shadow_slots [DEPTH];
  int                       shadow_front = 0;
  int                       shadow_count = 0;

  // Result beats still owed by the core, oldest first
  rsp_t pending_rsp [$];

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue_core test failed");
      $finish;
    end
  end

  // Back-pressure the response side at random; changes land on the falling edge
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic void flag_error(string what, rsp_t want, rsp_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s at cycle %0d: expected data=%0d status=%0d occ=%0d last=%0b",
               what, cycle_count, want.data, want.status, want.occupancy, want.last);
      $display("  got data=%0d status=%0d occ=%0d last=%0b",
               got.data, got.status, got.occupancy, got.last);
    end
  endfunction

  function automatic int ring_slot(int offset);
    return (shadow_front + offset) % DEPTH;
  endfunction

  // Apply one command to the shadow deque and queue up the beats it must produce
  function automatic void apply_deque_cmd(req_t item);
    rsp_t beat;
    int   take;
    beat      = '0;
    beat.last = 1'b1;
    case (item.cmd)
      CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
        // Push beats carry zero data, accepted or refused
        if (shadow_count >= DEPTH) begin
          beat.status = STATUS_FULL;
        end else if (item.cmd == CMD_PUSH_REAR) begin
          shadow_slots[ring_slot(shadow_count)] = item.value;
          shadow_count++;
        end else begin
          shadow_front = ring_slot(DEPTH - 1);
          shadow_slots[shadow_front] = item.value;
          shadow_count++;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (shadow_count == 0) begin
          beat.data   = NEG_ONE;
          beat.status = STATUS_EMPTY;
        end else if (item.cmd == CMD_POP_FRONT) begin
          beat.data    = shadow_slots[shadow_front];
          shadow_front = ring_slot(1);
          shadow_count--;
        end else begin
          beat.data = shadow_slots[ring_slot(shadow_count - 1)];
          shadow_count--;
        end
      end
      CMD_FIND: begin
        // Position is 1-based; zero or past the end is out of range
        if (item.position < 1 || item.position > shadow_count) begin
          beat.data   = NEG_ONE;
          beat.status = STATUS_EMPTY;
        end else begin
          beat.data = shadow_slots[ring_slot(item.position - 1)];
        end
      end
      CMD_REMOVE: begin
        // Clip to the element count; always reports ok
        take         = (item.remove_count > shadow_count) ? shadow_count : item.remove_count;
        shadow_front = ring_slot(take);
        shadow_count -= take;
      end
      default: begin
        // Dump in either direction: one beat per element, or a lone empty beat
        if (shadow_count == 0) begin
          beat.data   = NEG_ONE;
          beat.status = STATUS_EMPTY;
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            beat.data      = shadow_slots[ring_slot((item.cmd == CMD_DUMP) ? i
                                                    : shadow_count - 1 - i)];
            beat.status    = STATUS_OK;
            beat.occupancy = OCC_W'(shadow_count);
            beat.last      = (i == shadow_count - 1);
            pending_rsp.push_back(beat);
          end
          return;
        end
      end
    endcase
    beat.occupancy = OCC_W'(shadow_count);
    pending_rsp.push_back(beat);
  endfunction

  // Compare every accepted response beat with the oldest one owed
  always @(posedge clk) begin : check_beats
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        flag_error("Beat with nothing expected", '0, rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.data !== want.data || rsp.status !== want.status ||
            rsp.occupancy !== want.occupancy || rsp.last !== want.last) begin
          flag_error("Beat mismatch", want, rsp);
        end
      end
    end
  end

  // Send one request beat. Called at a falling edge, returns at a falling edge with
  // valid still high, so back-to-back beats drop valid only for random idle gaps.
  task automatic send_cmd(input req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_deque_cmd(item);
    @(negedge clk);
  endtask

  function automatic req_t make_req(logic [2:0] cmd, logic signed [WORD_W-1:0] value,
                                    int position, int remove_count);
    req_t item;
    item.cmd          = cmd;
    item.value        = value;
    item.position     = POS_W'(position);
    item.remove_count = POS_W'(remove_count);
    return item;
  endfunction

  // Fill every field with noise, then steer position and count toward the live range
  function automatic req_t random_req(logic [2:0] cmd);
    req_t item;
    item.cmd   = cmd;
    item.value = $urandom();
    case ($urandom_range(7))
      0:       item.value = 32'h7fff_ffff;
      1:       item.value = 32'h8000_0000;
      default: ;
    endcase
    item.position     = ($urandom_range(3) == 0) ? POS_W'($urandom_range(1023))
                                                 : POS_W'($urandom_range(shadow_count + 1));
    item.remove_count = ($urandom_range(7) == 0) ? POS_W'($urandom())
                                                 : POS_W'($urandom_range(4));
    return item;
  endfunction

  function automatic logic [2:0] pick_cmd();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20)      return CMD_PUSH_REAR;
    else if (roll < 40) return CMD_PUSH_FRONT;
    else if (roll < 52) return CMD_POP_FRONT;
    else if (roll < 64) return CMD_POP_REAR;
    else if (roll < 78) return CMD_FIND;
    else if (roll < 86) return CMD_REMOVE;
    else if (roll < 93) return CMD_DUMP;
    else                return CMD_DUMP_REV;
  endfunction

  // Every command but the pushes against an empty deque
  task automatic test_empty_deque();
    send_cmd(random_req(CMD_POP_FRONT));
    send_cmd(random_req(CMD_POP_REAR));
    send_cmd(make_req(CMD_FIND, $urandom(), 0, 0));
    send_cmd(make_req(CMD_FIND, $urandom(), 1, 0));
    send_cmd(make_req(CMD_REMOVE, $urandom(), 0, 5));
    send_cmd(random_req(CMD_DUMP));
    send_cmd(random_req(CMD_DUMP_REV));
  endtask

  // Extreme words at both ends, range edges of find, clipped remove
  task automatic test_basic_ops();
    send_cmd(make_req(CMD_PUSH_REAR,  32'h7fff_ffff, 1023, 1023));
    send_cmd(make_req(CMD_PUSH_FRONT, 32'h8000_0000, 0, 0));
    send_cmd(make_req(CMD_PUSH_REAR,  NEG_ONE, 0, 0));
    send_cmd(make_req(CMD_PUSH_FRONT, 32'h0, 1023, 1023));
    send_cmd(make_req(CMD_FIND, 32'h0, 1, 0));
    send_cmd(make_req(CMD_FIND, 32'h0, 4, 0));
    send_cmd(make_req(CMD_FIND, 32'h0, 5, 0));
    send_cmd(make_req(CMD_FIND, NEG_ONE, 1023, 1023));
    send_cmd(random_req(CMD_DUMP));
    send_cmd(random_req(CMD_DUMP_REV));
    send_cmd(make_req(CMD_POP_FRONT, 32'h0, 0, 0));
    send_cmd(make_req(CMD_POP_REAR, 32'h0, 0, 0));
    send_cmd(make_req(CMD_REMOVE, 32'h0, 0, 1023));
    send_cmd(random_req(CMD_DUMP));
  endtask

  // Fill to capacity, get refused at both ends, then read and trim a full ring
  task automatic test_full_deque();
    while (shadow_count < DEPTH) begin
      send_cmd(random_req($urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR));
    end
    send_cmd(random_req(CMD_PUSH_REAR));
    send_cmd(random_req(CMD_PUSH_FRONT));
    send_cmd(make_req(CMD_FIND, $urandom(), DEPTH, 0));
    send_cmd(make_req(CMD_FIND, $urandom(), DEPTH + 1, 0));
    send_cmd(random_req(CMD_DUMP));
    send_cmd(random_req(CMD_DUMP_REV));
    send_cmd(random_req(CMD_POP_FRONT));
    send_cmd(random_req(CMD_POP_REAR));
    send_cmd(random_req(CMD_PUSH_FRONT));
    send_cmd(random_req(CMD_PUSH_REAR));
    send_cmd(make_req(CMD_REMOVE, $urandom(), 0, DEPTH - 4));
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      send_cmd(random_req(pick_cmd()));
    end
  endtask

  initial begin
    // Hold reset, release on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sparse requests, heavy back-pressure
    send_idle_pct = 36;
    recv_idle_pct = 77;
    test_empty_deque();
    test_basic_ops();
    test_random_traffic(27);

    // Bursty responses, sparse requests swapped
    send_idle_pct = 77;
    recv_idle_pct = 36;
    test_full_deque();
    test_random_traffic(27);

    // Full throughput on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(27);

    // Drop valid, drain what is owed, then watch for stray beats
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("double_ended_queue_core test passed");
    end else begin
      $display("double_ended_queue_core test failed");
    end
    $finish;
  end

endmodule
